[rtl/core/tpp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tpp_pkg;

  // Value format: unsigned fixed point, W bits with F fraction bits.
  localparam int W = 32;
  localparam int F = 16;
  localparam int THR_W = 16;
  localparam int CFG_IDX_W = 4;

  // Intermediate widths, all exact.
  localparam int TQ_W = W + F;          // v / a in fixed point
  localparam int HALF_W = 2 * W - 1;    // v*v / (2a)
  localparam int SUM_W = 2 * W + 1;     // accel plus decel length, coast length magnitude
  localparam int DIV_NUM_W = SUM_W + F; // widest dividend (coast length shifted)
  localparam int DIV_LAT = DIV_NUM_W;   // one quotient bit per stage
  localparam int TC_W = TQ_W + 3;       // clamped coast time, well above any phase time sum
  localparam int TOT_W = TC_W + 1;
  localparam int SQRT_LAT = W;          // one root bit per stage
  localparam int PLAN_LAT = 2 * DIV_LAT + 5;
  localparam int OUT_LAT = SQRT_LAT + PLAN_LAT + 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_THR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COAST_TOL = CFG_IDX_W'(1);

  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic                vld;
    logic                err;
    logic [W-1:0]        v;
    logic [TQ_W-1:0]     ta;
    logic [TQ_W-1:0]     td;
    logic [HALF_W-1:0]   la;
    logic [HALF_W-1:0]   ld;
    logic                lc_neg;
    logic [SUM_W-1:0]    lc;
    logic                ds_neg;
    logic [HALF_W-1:0]   ds;
    logic                tc_neg;
    logic [TC_W-1:0]     tc;
    logic [TOT_W-1:0]    tot;
  } plan_res_t;

  function automatic logic is_zero(input logic [W-1:0] x, input logic [THR_W-1:0] thr);
    return (x == '0) || (x < W'(thr));
  endfunction

  function automatic logic [W-1:0] sat_u(input logic [SUM_W-1:0] x);
    return (|x[SUM_W-1:W]) ? {W{1'b1}} : x[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_s(input logic neg, input logic [SUM_W-1:0] mag);
    logic hi_nz;
    logic [W-1:0] lo;
    hi_nz = |mag[SUM_W-1:W];
    lo = mag[W-1:0];
    if (!neg) begin
      return (hi_nz || lo[W-1]) ? SMAX : lo;
    end
    return (hi_nz || (lo > SMIN)) ? SMIN : (W'(0) - lo);
  endfunction

endpackage

`default_nettype wire

[rtl/core/tpp_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per pipeline stage.
module tpp_div (
  input  logic                            clk,
  input  logic [tpp_pkg::DIV_NUM_W-1:0]   num,
  input  logic [tpp_pkg::W-1:0]           den,
  output logic [tpp_pkg::DIV_NUM_W-1:0]   quo
);
  import tpp_pkg::*;

  logic [DIV_NUM_W-1:0] num_r [DIV_LAT];
  logic [DIV_NUM_W-1:0] quo_r [DIV_LAT];
  logic [W-1:0]         rem_r [DIV_LAT];
  logic [W-1:0]         den_r [DIV_LAT];

  genvar gi;
  for (gi = 0; gi < DIV_LAT; gi++) begin : g_stage
    logic [DIV_NUM_W-1:0] num_in;
    logic [DIV_NUM_W-1:0] quo_in;
    logic [W-1:0]         rem_in;
    logic [W-1:0]         den_in;
    logic [W:0]           trial;
    logic                 take;
    if (gi == 0) begin : g_first
      assign num_in = num;
      assign quo_in = '0;
      assign rem_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign num_in = num_r[gi-1];
      assign quo_in = quo_r[gi-1];
      assign rem_in = rem_r[gi-1];
      assign den_in = den_r[gi-1];
    end
    assign trial = {rem_in, num_in[DIV_NUM_W-1]};
    assign take = trial >= {1'b0, den_in};
    always_ff @(posedge clk) begin
      num_r[gi] <= num_in << 1;
      quo_r[gi] <= {quo_in[DIV_NUM_W-2:0], take};
      rem_r[gi] <= take ? W'(trial - {1'b0, den_in}) : trial[W-1:0];
      den_r[gi] <= den_in;
    end
  end

  assign quo = quo_r[DIV_LAT-1];

endmodule

`default_nettype wire

[rtl/core/tpp_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none

// Digit-by-digit integer square root, one root bit per pipeline stage.
module tpp_sqrt (
  input  logic                    clk,
  input  logic [2*tpp_pkg::W-1:0] rad,
  output logic [tpp_pkg::W-1:0]   root
);
  import tpp_pkg::*;

  logic [2*W-1:0] rad_r  [SQRT_LAT];
  logic [W-1:0]   root_r [SQRT_LAT];
  logic [W+1:0]   rem_r  [SQRT_LAT];

  genvar gi;
  for (gi = 0; gi < SQRT_LAT; gi++) begin : g_stage
    logic [2*W-1:0] rad_in;
    logic [W-1:0]   root_in;
    logic [W+1:0]   rem_in;
    logic [W+3:0]   trial_rem;
    logic [W+1:0]   trial;
    logic           take;
    if (gi == 0) begin : g_first
      assign rad_in = rad;
      assign root_in = '0;
      assign rem_in = '0;
    end else begin : g_next
      assign rad_in = rad_r[gi-1];
      assign root_in = root_r[gi-1];
      assign rem_in = rem_r[gi-1];
    end
    assign trial_rem = {rem_in, rad_in[2*W-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign take = trial_rem >= (W+4)'(trial);
    always_ff @(posedge clk) begin
      rad_r[gi]  <= rad_in << 2;
      root_r[gi] <= {root_in[W-2:0], take};
      rem_r[gi]  <= take ? (W+2)'(trial_rem - (W+4)'(trial)) : trial_rem[W+1:0];
    end
  end

  assign root = root_r[SQRT_LAT-1];

endmodule

`default_nettype wire

[rtl/core/tpp_plan.sv]
`timescale 1ns / 1ps
`default_nettype none

// One full plan for a given distance, acceleration and velocity.
module tpp_plan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [tpp_pkg::THR_W-1:0]   thr,
  input  logic                        in_vld,
  input  logic [tpp_pkg::W-1:0]       d,
  input  logic [tpp_pkg::W-1:0]       a,
  input  logic [tpp_pkg::W-1:0]       v,
  output tpp_pkg::plan_res_t          res
);
  import tpp_pkg::*;

  typedef struct packed {
    logic         vld;
    logic         err;
    logic [W-1:0] d;
    logic [W-1:0] v;
    logic         az;
    logic         vz;
    logic         anz;
  } side_a_t;

  typedef struct packed {
    logic              vld;
    logic              err;
    logic [W-1:0]      v;
    logic              vz;
    logic [TQ_W-1:0]   ta;
    logic [TQ_W-1:0]   td;
    logic [HALF_W-1:0] la;
    logic [HALF_W-1:0] ld;
    logic              lc_neg;
    logic [SUM_W-1:0]  lc;
    logic              ds_neg;
    logic [HALF_W-1:0] ds;
  } side_c_t;

  // Stage A: operands for the two divisions by the acceleration.
  side_a_t          a_r;
  logic [2*W-1:0]   a_vv_r;
  logic [W-1:0]     a_den_r;
  logic [DIV_NUM_W-1:0] q_tq, q_vv;
  side_a_t          sa_r [DIV_LAT];

  // Stage B: phase times and lengths.
  logic              b_vld_r, b_err_r, b_vz_r;
  logic [W-1:0]      b_d_r, b_v_r;
  logic [TQ_W-1:0]   b_ta_r, b_td_r;
  logic [HALF_W-1:0] b_la_r, b_ld_r;
  logic [SUM_W-1:0]  b_sum_r;
  logic [TQ_W-1:0]   tq;
  logic [HALF_W-1:0] half;
  logic              td_zero;

  // Stage C: coast length and decel start.
  side_c_t          c_nxt, c_r;
  logic [W-1:0]     c_den_r;
  logic [DIV_NUM_W-1:0] q_tc;
  side_c_t          sc_r [DIV_LAT];

  // Stages D and E: coast time and total time.
  plan_res_t        d_nxt, d_r, e_nxt, e_r;
  logic [TOT_W-1:0] pos;

  always_ff @(posedge clk) begin
    a_r.vld <= in_vld;
    a_r.err <= (a == '0) && !is_zero(v, thr);
    a_r.d   <= d;
    a_r.v   <= v;
    a_r.az  <= is_zero(a, thr);
    a_r.vz  <= is_zero(v, thr);
    a_r.anz <= a != '0;
    a_vv_r  <= v * v;
    a_den_r <= (a == '0) ? W'(1) : a;
    if (!rst_n) begin
      a_r.vld <= 1'b0;
    end
  end

  tpp_div u_div_tq (
    .clk (clk),
    .num (DIV_NUM_W'({a_r.v, {F{1'b0}}})),
    .den (a_den_r),
    .quo (q_tq)
  );

  tpp_div u_div_vv (
    .clk (clk),
    .num (DIV_NUM_W'(a_vv_r)),
    .den (a_den_r),
    .quo (q_vv)
  );

  always_ff @(posedge clk) begin
    sa_r[0] <= a_r;
    for (int k = 1; k < DIV_LAT; k++) begin
      sa_r[k] <= sa_r[k-1];
    end
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        sa_r[k].vld <= 1'b0;
      end
    end
  end

  assign tq = q_tq[TQ_W-1:0];
  assign half = q_vv[HALF_W:1];
  assign td_zero = sa_r[DIV_LAT-1].vz || !sa_r[DIV_LAT-1].anz;

  always_ff @(posedge clk) begin
    b_vld_r <= sa_r[DIV_LAT-1].vld;
    b_err_r <= sa_r[DIV_LAT-1].err;
    b_vz_r  <= sa_r[DIV_LAT-1].vz;
    b_d_r   <= sa_r[DIV_LAT-1].d;
    b_v_r   <= sa_r[DIV_LAT-1].v;
    b_ta_r  <= sa_r[DIV_LAT-1].az ? '0 : tq;
    b_td_r  <= td_zero ? '0 : tq;
    b_la_r  <= sa_r[DIV_LAT-1].az ? '0 : half;
    b_ld_r  <= td_zero ? '0 : half;
    b_sum_r <= SUM_W'(sa_r[DIV_LAT-1].az ? '0 : half) + SUM_W'(td_zero ? '0 : half);
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end
  end

  always_comb begin
    c_nxt.vld    = b_vld_r;
    c_nxt.err    = b_err_r;
    c_nxt.v      = b_v_r;
    c_nxt.vz     = b_vz_r;
    c_nxt.ta     = b_ta_r;
    c_nxt.td     = b_td_r;
    c_nxt.la     = b_la_r;
    c_nxt.ld     = b_ld_r;
    c_nxt.lc_neg = b_sum_r > SUM_W'(b_d_r);
    c_nxt.lc     = c_nxt.lc_neg ? b_sum_r - SUM_W'(b_d_r) : SUM_W'(b_d_r) - b_sum_r;
    c_nxt.ds_neg = b_ld_r > HALF_W'(b_d_r);
    c_nxt.ds     = c_nxt.ds_neg ? b_ld_r - HALF_W'(b_d_r) : HALF_W'(b_d_r) - b_ld_r;
  end

  always_ff @(posedge clk) begin
    c_r     <= c_nxt;
    c_den_r <= (b_v_r == '0) ? W'(1) : b_v_r;
    if (!rst_n) begin
      c_r.vld <= 1'b0;
    end
  end

  tpp_div u_div_tc (
    .clk (clk),
    .num ({c_r.lc, {F{1'b0}}}),
    .den (c_den_r),
    .quo (q_tc)
  );

  always_ff @(posedge clk) begin
    sc_r[0] <= c_r;
    for (int k = 1; k < DIV_LAT; k++) begin
      sc_r[k] <= sc_r[k-1];
    end
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        sc_r[k].vld <= 1'b0;
      end
    end
  end

  // The coast time is clamped far above any accel plus decel time, which
  // keeps the total exact while the adders stay narrow.
  always_comb begin
    d_nxt.vld    = sc_r[DIV_LAT-1].vld;
    d_nxt.err    = sc_r[DIV_LAT-1].err;
    d_nxt.v      = sc_r[DIV_LAT-1].v;
    d_nxt.ta     = sc_r[DIV_LAT-1].ta;
    d_nxt.td     = sc_r[DIV_LAT-1].td;
    d_nxt.la     = sc_r[DIV_LAT-1].la;
    d_nxt.ld     = sc_r[DIV_LAT-1].ld;
    d_nxt.lc_neg = sc_r[DIV_LAT-1].lc_neg;
    d_nxt.lc     = sc_r[DIV_LAT-1].lc;
    d_nxt.ds_neg = sc_r[DIV_LAT-1].ds_neg;
    d_nxt.ds     = sc_r[DIV_LAT-1].ds;
    d_nxt.tc_neg = sc_r[DIV_LAT-1].lc_neg && !sc_r[DIV_LAT-1].vz;
    if (sc_r[DIV_LAT-1].vz) begin
      d_nxt.tc = '0;
    end else if (|q_tc[DIV_NUM_W-1:TC_W]) begin
      d_nxt.tc = {TC_W{1'b1}};
    end else begin
      d_nxt.tc = q_tc[TC_W-1:0];
    end
    d_nxt.tot    = TOT_W'(sc_r[DIV_LAT-1].ta) + TOT_W'(sc_r[DIV_LAT-1].td);
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end
  end

  // In stage D the tot field carries the accel plus decel time.
  assign pos = d_r.tot;

  always_comb begin
    e_nxt = d_r;
    if (!d_r.tc_neg) begin
      e_nxt.tot = pos + TOT_W'(d_r.tc);
    end else if (TOT_W'(d_r.tc) > pos) begin
      e_nxt.tot = '0;
    end else begin
      e_nxt.tot = pos - TOT_W'(d_r.tc);
    end
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt;
    if (!rst_n) begin
      e_r.vld <= 1'b0;
    end
  end

  assign res = e_r;

endmodule

`default_nettype wire

[rtl/core/trapezoid_profile_planner_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Trapezoidal profile planner. A move request (distance, acceleration limit,
// velocity limit, unsigned Q16.16) is taken on any clock edge where start is
// high and busy is low. Busy is only high while in reset, so one request per
// cycle is taken. Every request produces exactly one result, which is shown
// on the result ports once it has passed the square root, the plan units and
// the output register, and is flagged by a single-cycle out_valid pulse. The
// receiver cannot stall the block and must capture each result in the cycle
// it is shown. The pipelined square root (one root bit per stage, 32 stages)
// is followed by plan units, each holding three bit-per-stage dividers (81
// stages each), two of them in series. Configuration registers may only be
// written while no request is in flight.
module trapezoid_profile_planner_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tpp_pkg::W-1:0]         in_move_distance,
  input  logic [tpp_pkg::W-1:0]         in_accel_limit,
  input  logic [tpp_pkg::W-1:0]         in_vel_limit,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpp_pkg::THR_W-1:0]     cfg_data,
  output logic                          out_valid,
  output logic [tpp_pkg::W-1:0]         out_accel_time,
  output logic signed [tpp_pkg::W-1:0]  out_coast_time,
  output logic [tpp_pkg::W-1:0]         out_decel_time,
  output logic [tpp_pkg::W-1:0]         out_total_time,
  output logic [tpp_pkg::W-1:0]         out_accel_length,
  output logic signed [tpp_pkg::W-1:0]  out_coast_length,
  output logic [tpp_pkg::W-1:0]         out_decel_length,
  output logic signed [tpp_pkg::W-1:0]  out_decel_start,
  output logic [tpp_pkg::W-1:0]         out_cruise_velocity,
  output logic                          out_velocity_reduced,
  output logic                          out_plan_error
);
  import tpp_pkg::*;

  typedef struct packed {
    logic         vld;
    logic [W-1:0] d;
    logic [W-1:0] a;
    logic [W-1:0] v;
  } move_t;

  logic             busy_r;
  logic [THR_W-1:0] zero_thr_r;
  logic [THR_W-1:0] coast_tol_r;
  move_t            in_r;
  logic [2*W-1:0]   prod_r;
  logic [W-1:0]     v_root;
  move_t            mv_r [SQRT_LAT+1];
  plan_res_t        res_a, res_b, sel;
  logic             reduce;

  logic             out_valid_r;
  logic [W-1:0]     accel_time_r, coast_time_r, decel_time_r, total_time_r;
  logic [W-1:0]     accel_length_r, coast_length_r, decel_length_r, decel_start_r;
  logic [W-1:0]     cruise_velocity_r;
  logic             velocity_reduced_r, plan_error_r;

  // Busy only covers reset; the pipeline takes a request every cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_thr_r  <= THR_W'(1);
      coast_tol_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ZERO_THR:  zero_thr_r <= cfg_data;
        CFG_COAST_TOL: coast_tol_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the request, then form distance times acceleration for the
  // root that gives the triangular cruise velocity.
  always_ff @(posedge clk) begin
    in_r.vld <= start && !busy_r;
    in_r.d   <= in_move_distance;
    in_r.a   <= in_accel_limit;
    in_r.v   <= in_vel_limit;
    prod_r   <= in_r.d * in_r.a;
    if (!rst_n) begin
      in_r.vld <= 1'b0;
    end
  end

  tpp_sqrt u_sqrt (
    .clk  (clk),
    .rad  (prod_r),
    .root (v_root)
  );

  // Hold the request until the root is ready so both plans start together.
  always_ff @(posedge clk) begin
    mv_r[0] <= in_r;
    for (int k = 1; k <= SQRT_LAT; k++) begin
      mv_r[k] <= mv_r[k-1];
    end
    if (!rst_n) begin
      for (int k = 0; k <= SQRT_LAT; k++) begin
        mv_r[k].vld <= 1'b0;
      end
    end
  end

  // Plan A uses the requested velocity; plan B the reduced one. Plan B is
  // only selected when plan A's coast length is negative at or beyond tolerance.
  tpp_plan u_plan_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .thr    (zero_thr_r),
    .in_vld (mv_r[SQRT_LAT].vld),
    .d      (mv_r[SQRT_LAT].d),
    .a      (mv_r[SQRT_LAT].a),
    .v      (mv_r[SQRT_LAT].v),
    .res    (res_a)
  );

  tpp_plan u_plan_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .thr    (zero_thr_r),
    .in_vld (mv_r[SQRT_LAT].vld),
    .d      (mv_r[SQRT_LAT].d),
    .a      (mv_r[SQRT_LAT].a),
    .v      (v_root),
    .res    (res_b)
  );

  assign reduce = res_a.lc_neg && (res_a.lc >= SUM_W'(coast_tol_r));
  assign sel = reduce ? res_b : res_a;

  // Output register: saturate each field. An acceleration of exactly zero
  // with a live velocity reports only the error flag.
  always_ff @(posedge clk) begin
    out_valid_r <= res_a.vld;
    if (res_a.err) begin
      accel_time_r       <= '0;
      coast_time_r       <= '0;
      decel_time_r       <= '0;
      total_time_r       <= '0;
      accel_length_r     <= '0;
      coast_length_r     <= '0;
      decel_length_r     <= '0;
      decel_start_r      <= '0;
      cruise_velocity_r  <= '0;
      velocity_reduced_r <= 1'b0;
      plan_error_r       <= 1'b1;
    end else begin
      accel_time_r       <= sat_u(SUM_W'(sel.ta));
      coast_time_r       <= sat_s(sel.tc_neg, SUM_W'(sel.tc));
      decel_time_r       <= sat_u(SUM_W'(sel.td));
      total_time_r       <= sat_u(SUM_W'(sel.tot));
      accel_length_r     <= sat_u(SUM_W'(sel.la));
      coast_length_r     <= sat_s(sel.lc_neg, sel.lc);
      decel_length_r     <= sat_u(SUM_W'(sel.ld));
      decel_start_r      <= sat_s(sel.ds_neg, SUM_W'(sel.ds));
      cruise_velocity_r  <= sel.v;
      velocity_reduced_r <= reduce;
      plan_error_r       <= 1'b0;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_accel_time       = accel_time_r;
  assign out_coast_time       = coast_time_r;
  assign out_decel_time       = decel_time_r;
  assign out_total_time       = total_time_r;
  assign out_accel_length     = accel_length_r;
  assign out_coast_length     = coast_length_r;
  assign out_decel_length     = decel_length_r;
  assign out_decel_start      = decel_start_r;
  assign out_cruise_velocity  = cruise_velocity_r;
  assign out_velocity_reduced = velocity_reduced_r;
  assign out_plan_error       = plan_error_r;

`ifndef NO_ASSERTIONS
  // Every result traces back to a request that the block took.
  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, OUT_LAT))
    else $error("result without matching request");

  // An error result shows zero accel time, total time and cruise velocity, and no reduced flag.
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_plan_error) |->
      (out_accel_time == '0 && out_total_time == '0 && out_cruise_velocity == '0 &&
       !out_velocity_reduced))
    else $error("error result has live fields");

  // The reduced velocity never exceeds the requested limit.
  a_reduce_lower: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_velocity_reduced) |->
      (out_cruise_velocity <= $past(in_vel_limit, OUT_LAT)))
    else $error("reduced velocity above requested limit");
`endif

endmodule

`default_nettype wire

[dv/trapezoid_profile_planner_checker.sv]
`timescale 1ns / 1ps

module trapezoid_profile_planner_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [tpp_pkg::W-1:0]         in_move_distance,
  input  logic [tpp_pkg::W-1:0]         in_accel_limit,
  input  logic [tpp_pkg::W-1:0]         in_vel_limit,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [tpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpp_pkg::THR_W-1:0]     cfg_data,
  input  logic                          out_valid,
  input  logic [tpp_pkg::W-1:0]         out_accel_time,
  input  logic [tpp_pkg::W-1:0]         out_coast_time,
  input  logic [tpp_pkg::W-1:0]         out_decel_time,
  input  logic [tpp_pkg::W-1:0]         out_total_time,
  input  logic [tpp_pkg::W-1:0]         out_accel_length,
  input  logic [tpp_pkg::W-1:0]         out_coast_length,
  input  logic [tpp_pkg::W-1:0]         out_decel_length,
  input  logic [tpp_pkg::W-1:0]         out_decel_start,
  input  logic [tpp_pkg::W-1:0]         out_cruise_velocity,
  input  logic                          out_velocity_reduced,
  input  logic                          out_plan_error,
  output int                            error_count,
  output int                            plans_pending
);

  import tpp_pkg::*;

  typedef logic [127:0] wide_t;

  typedef struct packed {
    logic [W-1:0] accel_time;
    logic [W-1:0] coast_time;
    logic [W-1:0] decel_time;
    logic [W-1:0] total_time;
    logic [W-1:0] accel_length;
    logic [W-1:0] coast_length;
    logic [W-1:0] decel_length;
    logic [W-1:0] decel_start;
    logic [W-1:0] cruise_velocity;
    logic         velocity_reduced;
    logic         plan_error;
  } profile_t;

  typedef struct {
    wide_t ta, td, la, ld, lc, ds, tc, tot;
    logic  lc_neg, ds_neg, tc_neg;
  } phases_t;

  logic [THR_W-1:0] zero_thr;
  logic [THR_W-1:0] coast_tol;
  profile_t         plan_expect_q[$];

  function automatic logic below_thr(logic [W-1:0] x, logic [THR_W-1:0] thr);
    return (x == 0) || (x < thr);
  endfunction

  function automatic logic [W-1:0] clamp_u(wide_t x);
    return (x > wide_t'({W{1'b1}})) ? {W{1'b1}} : x[W-1:0];
  endfunction

  function automatic logic [W-1:0] clamp_s(logic neg, wide_t mag);
    wide_t smax;
    smax = wide_t'(SMAX);
    if (!neg) return (mag > smax) ? SMAX : mag[W-1:0];
    return (mag > smax + 1) ? SMIN : (W'(0) - mag[W-1:0]);
  endfunction

  function automatic phases_t split_move(logic [W-1:0] d, logic [W-1:0] a, logic [W-1:0] v,
                                         logic [THR_W-1:0] thr);
    phases_t p;
    wide_t   tq, half, dw, ramps, pos;
    logic    az, vz;
    az = below_thr(a, thr);
    vz = below_thr(v, thr);
    tq = 0;
    half = 0;
    dw = wide_t'(d);
    if (a != 0) begin
      tq = (wide_t'(v) << F) / wide_t'(a);
      half = ((wide_t'(v) * wide_t'(v)) / wide_t'(a)) >> 1;
    end
    p.ta = az ? 0 : tq;
    p.la = az ? 0 : half;
    p.td = vz ? 0 : tq;
    p.ld = vz ? 0 : half;
    ramps = p.la + p.ld;
    p.lc_neg = dw < ramps;
    p.lc = p.lc_neg ? ramps - dw : dw - ramps;
    p.ds_neg = dw < p.ld;
    p.ds = p.ds_neg ? p.ld - dw : dw - p.ld;
    p.tc = vz ? 0 : (p.lc << F) / wide_t'(v);
    p.tc_neg = p.lc_neg && !vz;
    pos = p.ta + p.td;
    if (!p.tc_neg) p.tot = pos + p.tc;
    else p.tot = (p.tc > pos) ? 0 : pos - p.tc;
    return p;
  endfunction

  function automatic logic [W-1:0] floor_root(wide_t n);
    logic [63:0] r;
    logic [63:0] c;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (wide_t'(c) * wide_t'(c) <= n) r = c;
    end
    return r[W-1:0];
  endfunction

  function automatic profile_t predict_profile(logic [W-1:0] d, logic [W-1:0] a,
                                               logic [W-1:0] v, logic [THR_W-1:0] thr,
                                               logic [THR_W-1:0] tol);
    profile_t r;
    phases_t  p;
    r = '0;
    if (a == 0 && !below_thr(v, thr)) begin
      r.plan_error = 1'b1;
      return r;
    end
    p = split_move(d, a, v, thr);
    if (p.lc_neg && p.lc >= wide_t'(tol)) begin
      v = floor_root(wide_t'(d) * wide_t'(a));
      p = split_move(d, a, v, thr);
      r.velocity_reduced = 1'b1;
    end
    r.accel_time = clamp_u(p.ta);
    r.coast_time = clamp_s(p.tc_neg, p.tc);
    r.decel_time = clamp_u(p.td);
    r.total_time = clamp_u(p.tot);
    r.accel_length = clamp_u(p.la);
    r.coast_length = clamp_s(p.lc_neg, p.lc);
    r.decel_length = clamp_u(p.ld);
    r.decel_start = clamp_s(p.ds_neg, p.ds);
    r.cruise_velocity = v;
    return r;
  endfunction

  task automatic compare_field(string name, logic [W-1:0] exp_v, logic [W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  initial error_count = 0;

  always @(posedge clk) begin
    profile_t e;
    if (!rst_n) begin
      zero_thr <= THR_W'(1);
      coast_tol <= '0;
      plan_expect_q.delete();
      plans_pending <= 0;
    end else begin
      if (start && !busy) begin
        plan_expect_q = {plan_expect_q,
                         predict_profile(in_move_distance, in_accel_limit, in_vel_limit,
                                         zero_thr, coast_tol)};
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ZERO_THR) zero_thr <= cfg_data;
        else if (cfg_index == CFG_COAST_TOL) coast_tol <= cfg_data;
      end
      if (out_valid) begin
        if (plan_expect_q.size() == 0) begin
          $display("%0t: result with no request waiting, expected none, actual %h",
                   $time, out_total_time);
          error_count++;
        end else begin
          e = plan_expect_q.pop_front();
          compare_field("accel_time", e.accel_time, out_accel_time);
          compare_field("coast_time", e.coast_time, out_coast_time);
          compare_field("decel_time", e.decel_time, out_decel_time);
          compare_field("total_time", e.total_time, out_total_time);
          compare_field("accel_length", e.accel_length, out_accel_length);
          compare_field("coast_length", e.coast_length, out_coast_length);
          compare_field("decel_length", e.decel_length, out_decel_length);
          compare_field("decel_start", e.decel_start, out_decel_start);
          compare_field("cruise_velocity", e.cruise_velocity, out_cruise_velocity);
          compare_field("velocity_reduced", W'(e.velocity_reduced), W'(out_velocity_reduced));
          compare_field("plan_error", W'(e.plan_error), W'(out_plan_error));
        end
      end
      plans_pending <= plan_expect_q.size();
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  import tpp_pkg::*;

  // The run is short compared to this; it only catches a hung block.
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_MOVES = 1330;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [W-1:0]         in_move_distance = '0;
  logic [W-1:0]         in_accel_limit = '0;
  logic [W-1:0]         in_vel_limit = '0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [THR_W-1:0]     cfg_data = '0;
  logic                 out_valid;
  logic [W-1:0]         out_accel_time;
  logic signed [W-1:0]  out_coast_time;
  logic [W-1:0]         out_decel_time;
  logic [W-1:0]         out_total_time;
  logic [W-1:0]         out_accel_length;
  logic signed [W-1:0]  out_coast_length;
  logic [W-1:0]         out_decel_length;
  logic signed [W-1:0]  out_decel_start;
  logic [W-1:0]         out_cruise_velocity;
  logic                 out_velocity_reduced;
  logic                 out_plan_error;
  int                   error_count;
  int                   plans_pending;
  int                   cycle_count = 0;
  logic                 idle_allowed = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  trapezoid_profile_planner_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_move_distance     (in_move_distance),
    .in_accel_limit       (in_accel_limit),
    .in_vel_limit         (in_vel_limit),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_accel_time       (out_accel_time),
    .out_coast_time       (out_coast_time),
    .out_decel_time       (out_decel_time),
    .out_total_time       (out_total_time),
    .out_accel_length     (out_accel_length),
    .out_coast_length     (out_coast_length),
    .out_decel_length     (out_decel_length),
    .out_decel_start      (out_decel_start),
    .out_cruise_velocity  (out_cruise_velocity),
    .out_velocity_reduced (out_velocity_reduced),
    .out_plan_error       (out_plan_error)
  );

  trapezoid_profile_planner_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_move_distance     (in_move_distance),
    .in_accel_limit       (in_accel_limit),
    .in_vel_limit         (in_vel_limit),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_accel_time       (out_accel_time),
    .out_coast_time       (out_coast_time),
    .out_decel_time       (out_decel_time),
    .out_total_time       (out_total_time),
    .out_accel_length     (out_accel_length),
    .out_coast_length     (out_coast_length),
    .out_decel_length     (out_decel_length),
    .out_decel_start      (out_decel_start),
    .out_cruise_velocity  (out_cruise_velocity),
    .out_velocity_reduced (out_velocity_reduced),
    .out_plan_error       (out_plan_error),
    .error_count          (error_count),
    .plans_pending        (plans_pending)
  );

  // Watchdog. A healthy run finishes far below this count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Presents one move request and holds it until the block takes it. Start is
  // left high so that back-to-back requests never drop it within a step; an
  // optional idle burst afterwards lowers it and scrambles the distance.
  task automatic send_move(logic [W-1:0] mv_dist, logic [W-1:0] acc, logic [W-1:0] vel);
    start <= 1'b1;
    in_move_distance <= mv_dist;
    in_accel_limit <= acc;
    in_vel_limit <= vel;
    do @(posedge clk); while (busy);
    if (idle_allowed && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      in_move_distance <= $urandom;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Registers are only written with nothing in flight. Every request yields a
  // result, so an empty expectation queue means the pipeline is drained.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (plans_pending != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Draws a value from a spread of magnitudes: zero, tiny values around the
  // zero threshold, all ones, and random values of random bit length.
  function automatic logic [W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel == 1) return {W{1'b1}};
    if (sel <= 3) return W'($urandom_range(0, 70000));
    return $urandom >> $urandom_range(0, 31);
  endfunction

  // Builds a move whose distance sits near the sum of both ramp lengths, so
  // that the coast length straddles zero and the triangular case is common.
  task automatic send_tight_move();
    logic [W-1:0]   acc, vel, mv_dist;
    logic [63:0]    ramps;
    acc = pick_value();
    vel = pick_value();
    if (acc == 0) acc = W'($urandom_range(1, 1000));
    ramps = (64'(vel) * 64'(vel)) / 64'(acc);
    ramps = ramps >> $urandom_range(0, 2);
    if ($urandom_range(0, 1)) ramps = ramps + 64'($urandom_range(0, 40000));
    else ramps = (ramps > 64'd40000) ? ramps - 64'($urandom_range(0, 40000)) : ramps;
    mv_dist = (ramps > 64'(~W'(0))) ? ~W'(0) : ramps[W-1:0];
    send_move(mv_dist, acc, vel);
  endtask

  task automatic send_random_moves(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 2) != 0) send_tight_move();
      else send_move(pick_value(), pick_value(), pick_value());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed moves under the reset settings: threshold 1, no tolerance.
    send_move('0, '0, '0);
    send_move({W{1'b1}}, {W{1'b1}}, {W{1'b1}});
    // Zero acceleration with a nonzero velocity raises the error flag.
    send_move(32'h0010_0000, '0, 32'h0002_0000);
    send_move({W{1'b1}}, '0, {W{1'b1}});
    // Zero acceleration and zero velocity is legal and gives zero phase times.
    send_move(32'h0005_0000, '0, '0);
    // A plain trapezoid with a real coast phase.
    send_move(32'h0064_0000, 32'h0002_0000, 32'h0004_0000);
    // Distance too short for full speed, so the profile turns triangular.
    send_move(32'h0001_0000, 32'h0001_0000, 32'h0010_0000);
    // Exact fit: ramps consume the whole distance, coast length is zero.
    send_move(32'h0004_0000, 32'h0001_0000, 32'h0002_0000);
    // Tiny acceleration with large velocity saturates times and lengths, then other extreme operand mixes.
    send_move({W{1'b1}}, 32'h0000_0001, {W{1'b1}});
    send_move('0, 32'h0000_0001, {W{1'b1}});
    send_move(32'h0000_0001, {W{1'b1}}, 32'h0000_0001);
    send_move({W{1'b1}}, 32'h8000_0000, 32'h7FFF_FFFF);
    send_move(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);

    // Large threshold: small limits count as zero, and a tiny but nonzero
    // acceleration gives a zero accel phase while decel uses the quotient.
    write_reg(CFG_ZERO_THR, 16'hFFFF);
    write_reg(CFG_COAST_TOL, 16'hFFFF);
    send_move(32'h0010_0000, 32'h0000_0100, 32'h0002_0000);
    send_move(32'h0010_0000, 32'h0000_0100, 32'h0000_0200);
    send_move(32'h0010_0000, '0, 32'h0000_FFFE);
    send_move(32'h0000_8000, 32'h0001_0000, 32'h0001_0000);
    send_move(32'h0000_0001, 32'h0000_FFFF, 32'h0001_0000);
    send_random_moves(RANDOM_MOVES / 5);

    // Threshold zero: only an exact zero counts as zero.
    write_reg(CFG_ZERO_THR, 16'h0000);
    write_reg(CFG_COAST_TOL, 16'h0000);
    send_move(32'h0001_0000, '0, 32'h0000_0001);
    send_move(32'h0001_0000, 32'h0000_0001, 32'h0000_0001);
    send_random_moves(RANDOM_MOVES / 5);

    write_reg(CFG_ZERO_THR, 16'h0100);
    write_reg(CFG_COAST_TOL, 16'h8000);
    send_random_moves(RANDOM_MOVES / 5);

    write_reg(CFG_ZERO_THR, THR_W'($urandom));
    write_reg(CFG_COAST_TOL, THR_W'($urandom));
    send_random_moves(RANDOM_MOVES / 5);

    // Back to the reset values, and no idling for the closing stretch.
    write_reg(CFG_ZERO_THR, 16'h0001);
    write_reg(CFG_COAST_TOL, 16'h0000);
    send_random_moves(RANDOM_MOVES / 10);
    idle_allowed = 1'b0;
    send_random_moves(RANDOM_MOVES / 10);
    start <= 1'b0;

    while (plans_pending != 0) @(posedge clk);
    repeat (OUT_LAT + 20) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/tpp_pkg.sv
rtl/core/tpp_div.sv
rtl/core/tpp_sqrt.sv
rtl/core/tpp_plan.sv
rtl/core/trapezoid_profile_planner_core.sv
dv/trapezoid_profile_planner_checker.sv
dv/testbench.sv
